/* rtl/pfe_pkg.sv */
// Package for the postfix expression evaluator: data width, symbol codes,
// status codes, cell operations and state machine states.
// No dependencies.
package pfe_pkg;

  localparam int DataWidth         = 32;
  localparam int SymbolWidth       = 8;
  localparam int StatusWidth       = 2;
  localparam int StackDepthDefault = 16;

  // ASCII codes of the characters that get special handling.
  localparam logic [SymbolWidth-1:0] SymAdd    = 8'h2B;
  localparam logic [SymbolWidth-1:0] SymSub    = 8'h2D;
  localparam logic [SymbolWidth-1:0] SymMul    = 8'h2A;
  localparam logic [SymbolWidth-1:0] SymDiv    = 8'h2F;
  localparam logic [SymbolWidth-1:0] SymLParen = 8'h28;
  localparam logic [SymbolWidth-1:0] SymRParen = 8'h29;

  // Offset subtracted from a character code before it is pushed.
  localparam logic [DataWidth-1:0] DigitBase = 32'd48;

  // Value returned by a pop from an empty stack.
  localparam logic [DataWidth-1:0] EmptyValue = '1;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DIV0 = 2'd1,
    STATUS_OVF  = 2'd2
  } status_e;

  // What a stack cell loads on the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FINISH
  } state_e;

endpackage

/* rtl/pfe_if.sv */
// Valid/ready channel interfaces for the postfix expression evaluator.
// Depends on pfe_pkg for field widths.
interface pfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfe_pkg::SymbolWidth-1:0] symbol;
  logic                          last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pfe_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pfe_pkg::DataWidth-1:0]  value;
  logic [pfe_pkg::StatusWidth-1:0]       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

/* rtl/pfe_cell.sv */
// One stack cell: holds a single stack entry and exchanges it with its
// neighbors. Depends on pfe_pkg.
module pfe_cell (
  input  logic                          clk_i,
  input  pfe_pkg::cell_op_e             op_i,
  input  logic [pfe_pkg::DataWidth-1:0] prev_i,
  input  logic [pfe_pkg::DataWidth-1:0] next_i,
  output logic [pfe_pkg::DataWidth-1:0] data_o
);
  import pfe_pkg::*;

  logic [DataWidth-1:0] data_q;
  logic [DataWidth-1:0] data_d;

  // Select what the cell holds after this edge.
  always_comb begin
    unique case (op_i)
      CELL_TAKE_PREV: data_d = prev_i;
      CELL_TAKE_NEXT: data_d = next_i;
      default:        data_d = data_q;
    endcase
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/pfe_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. Depends on pfe_pkg. The divisor must be nonzero.
module pfe_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pfe_pkg::DataWidth-1:0] dividend_i,
  input  logic [pfe_pkg::DataWidth-1:0] divisor_i,
  output logic                          done_o,
  output logic [pfe_pkg::DataWidth-1:0] quotient_o
);
  import pfe_pkg::*;

  localparam int CntW = $clog2(DataWidth + 1);

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DataWidth:0]   rem_q, rem_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic [DataWidth:0]   rem_shift;
  logic [DataWidth:0]   rem_sub;

  // Shift one dividend bit into the partial remainder and try a subtract.
  assign rem_shift = {rem_q[DataWidth-1:0], quo_q[DataWidth-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      // Work on magnitudes and fix the sign at the end.
      quo_d = dividend_i[DataWidth-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_d = divisor_i[DataWidth-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_d = dividend_i[DataWidth-1] ^ divisor_i[DataWidth-1];
      rem_d = '0;
      cnt_d = CntW'(DataWidth);
    end else if (cnt_q != '0) begin
      if (!rem_sub[DataWidth]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[DataWidth-2:0], 1'b1};
      end else begin
        rem_d = rem_shift;
        quo_d = {quo_q[DataWidth-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

/* rtl/postfix_expression_evaluator.sv */
// Postfix expression evaluator on a row of stack cells, top of stack in cell 0.
// Each accepted item passes through an execute state before the next one is accepted; a
// '/' with a nonzero divisor also waits in a divide state for the divider, one quotient bit per cycle.
// An item marked last also passes a finish state, which waits for the result register to be
// free; its result is registered there and a new item is accepted while it waits to be taken.
// Reset clears the stack count, the error flags and the result valid; cells are not cleared.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfe_pkg::StackDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o
);
  import pfe_pkg::*;

  localparam int CountW = $clog2(STACK_DEPTH + 1);

  state_e               state_q, state_d;
  logic [SymbolWidth-1:0] sym_q;
  logic                 last_q;
  logic [CountW-1:0]    count_q, count_d;
  logic                 div0_q, div0_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [DataWidth-1:0] out_value_q, out_value_d;
  status_e              out_status_q, out_status_d;

  logic [DataWidth-1:0] cell_data [STACK_DEPTH];
  cell_op_e             top_op, rest_op;
  logic [DataWidth-1:0] top_val;

  logic                 is_arith, is_paren;
  logic                 has_one, has_two, is_full;
  logic [DataWidth-1:0] x_val, y_val, arith_res, push_val;
  logic                 div_start, div_done;
  logic [DataWidth-1:0] div_quot;
  logic                 can_load;

  // Symbol decode and operand fetch; an empty slot reads as minus one.
  assign is_arith = (sym_q == SymAdd) || (sym_q == SymSub) ||
                    (sym_q == SymMul) || (sym_q == SymDiv);
  assign is_paren = (sym_q == SymLParen) || (sym_q == SymRParen);
  assign has_one  = (count_q >= CountW'(1));
  assign has_two  = (count_q >= CountW'(2));
  assign is_full  = (count_q == CountW'(STACK_DEPTH));
  assign y_val    = has_one ? cell_data[0] : EmptyValue;
  assign x_val    = has_two ? cell_data[1] : EmptyValue;
  assign push_val = {{(DataWidth-SymbolWidth){1'b0}}, sym_q} - DigitBase;
  assign can_load = !out_valid_q || out_o.ready;

  // Combinational operators; the multiplier keeps the low word only.
  always_comb begin
    unique case (sym_q)
      SymAdd:  arith_res = x_val + y_val;
      SymSub:  arith_res = x_val - y_val;
      SymMul:  arith_res = x_val * y_val;
      default: arith_res = '0;
    endcase
  end

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x_val),
    .divisor_i  (y_val),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if ((sym_q == SymDiv) && (y_val != '0)) state_d = S_DIV;
        else if (last_q)                         state_d = S_FINISH;
        else                                     state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_done) state_d = last_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (can_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Stack, flag and output register control.
  always_comb begin
    top_op       = CELL_HOLD;
    rest_op      = CELL_HOLD;
    top_val      = arith_res;
    count_d      = count_q;
    div0_d       = div0_q;
    ovf_d        = ovf_q;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    unique case (state_q)
      S_EXEC: begin
        if (is_arith) begin
          if ((sym_q == SymDiv) && (y_val != '0)) begin
            div_start = 1'b1;
          end else begin
            // Two pops and one push: the row moves up by one entry.
            if (sym_q == SymDiv) div0_d = 1'b1;
            top_op  = CELL_TAKE_PREV;
            rest_op = CELL_TAKE_NEXT;
            count_d = has_two ? (count_q - 1'b1) : CountW'(1);
          end
        end else if (!is_paren) begin
          if (is_full) begin
            ovf_d = 1'b1;
          end else begin
            top_val = push_val;
            top_op  = CELL_TAKE_PREV;
            rest_op = CELL_TAKE_PREV;
            count_d = count_q + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          top_val = div_quot;
          top_op  = CELL_TAKE_PREV;
          rest_op = CELL_TAKE_NEXT;
          count_d = has_two ? (count_q - 1'b1) : CountW'(1);
        end
      end
      S_FINISH: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = y_val;
          out_status_d = ovf_q ? STATUS_OVF : (div0_q ? STATUS_DIV0 : STATUS_OK);
          count_d      = '0;
          div0_d       = 1'b0;
          ovf_d        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Row of stack cells.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DataWidth-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = top_val;
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end
    pfe_cell u_cell (
      .clk_i  (clk_i),
      .op_i   ((i == 0) ? top_op : rest_op),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      div0_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      div0_q      <= div0_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: input capture and result.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sym_q  <= in_i.symbol;
      last_q <= in_i.last;
    end
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

endmodule

/* rtl/pfe_checker.sv */
// Port-level checks for the postfix expression evaluator, bound to the top.
// Depends on pfe_pkg and on the top level postfix_expression_evaluator.
module pfe_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           in_last_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [pfe_pkg::DataWidth-1:0]  out_value_i,
  input  logic [pfe_pkg::StatusWidth-1:0] out_status_i
);
  import pfe_pkg::*;

  // A stalled result transaction keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_status_i))
    else $error("result payload changed while stalled");

  // Input ready drops once an item is accepted, so items are never accepted back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  // An item that is not last never produces a result right away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared without a last item");

  // The status code is always one of the defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == STATUS_OK) || (out_status_i == STATUS_DIV0) ||
                    (out_status_i == STATUS_OVF))
    else $error("undefined status code");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.value),
  .out_status_i (out_o.status)
);
